@@ hdl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Word layouts, operation and status codes, and storage sizes shared by the
// cell chain and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int ELEMENT_BITS  = 32;
    localparam int PRIORITY_BITS = 16;
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     op;
        logic [ELEMENT_BITS-1:0]  element;
        logic [PRIORITY_BITS-1:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic [ELEMENT_BITS-1:0]  front_element;
        logic [PRIORITY_BITS-1:0] front_priority;
        logic                     is_empty;
        logic [CNT_W-1:0]         fill_count;
        logic [1:0]               status;
    } result_t;

    typedef struct packed {
        logic [ELEMENT_BITS-1:0]  element;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

@@ hdl/stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded max-first priority queue, stable on ties
// A row of cells kept sorted by priority, front at cell 0.
// ----------------------------------------------------------------------------
// One command word (insert or remove) is taken at every clock edge where
// start is high; busy stays low, so a new word may follow in each cycle.
// The result word for a command appears on result with done high exactly one
// cycle after the command is taken and stays for that one cycle only: the
// receiver must take it then, there is no way to hold it off. Each command
// costs one cycle, set by the cell chain: every cell compares its own
// priority against the new one and decides locally whether to hold, take the
// new entry or take its left neighbor's, so an insert or removal finishes in
// a single shift of the whole row. Equal priorities leave in arrival order.
// Removal from an empty queue and insertion into a full one leave the queue
// untouched and are flagged in status.
// ----------------------------------------------------------------------------
module stable_priority_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  spq_pkg::cmd_t      cmd,
    output logic               done,
    output spq_pkg::result_t   result
);

    logic                      accept;
    logic                      do_insert;
    logic                      do_remove;
    logic [spq_pkg::CNT_W-1:0] count_reg;
    logic [spq_pkg::CNT_W-1:0] count_next;
    logic [1:0]                status_reg;
    logic [1:0]                status_next;
    logic                      done_reg;
    spq_pkg::cell_ctrl_t       ctrl;

    logic            keep    [spq_pkg::QUEUE_DEPTH];
    spq_pkg::entry_t entries [spq_pkg::QUEUE_DEPTH];

    // the chain finishes every command in a single shift, so the block is never busy
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign do_insert = accept && (cmd.op == spq_pkg::OP_INSERT) &&
                       (count_reg != spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
    assign do_remove = accept && (cmd.op == spq_pkg::OP_REMOVE) &&
                       (count_reg != '0);

    assign ctrl.insert              = do_insert;
    assign ctrl.remove              = do_remove;
    assign ctrl.new_entry.element   = cmd.element;
    assign ctrl.new_entry.prio      = cmd.priority_req;

    // Cell 0 has no left neighbor: treat it as a keeping one so the new
    // entry lands there when the front ranks below it. The last cell has no
    // right neighbor; on removal it takes its own stale entry, which lies
    // beyond the fill count and is never read.
    genvar gi;
    generate
        for (gi = 0; gi < spq_pkg::QUEUE_DEPTH; gi++)
        begin : g_cell
            logic            occ;
            logic            lk;
            spq_pkg::entry_t le;
            spq_pkg::entry_t re;

            assign occ = count_reg > spq_pkg::CNT_W'(gi);

            if (gi == 0)
            begin : g_first
                assign lk = 1'b1;
                assign le = ctrl.new_entry;
            end
            else
            begin : g_mid
                assign lk = keep[gi-1];
                assign le = entries[gi-1];
            end

            if (gi == spq_pkg::QUEUE_DEPTH - 1)
            begin : g_last
                assign re = entries[gi];
            end
            else
            begin : g_inner
                assign re = entries[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occ),
                .left_keep   (lk),
                .left_entry  (le),
                .right_entry (re),
                .keep        (keep[gi]),
                .entry       (entries[gi])
            );
        end
    endgenerate

    // advance the fill count and pick the status for this command
    always_comb
    begin
        count_next  = count_reg;
        status_next = spq_pkg::ST_OK;
        if (accept)
        begin
            if (cmd.op == spq_pkg::OP_INSERT)
            begin
                if (do_insert)
                    count_next = count_reg + spq_pkg::CNT_W'(1);
                else
                    status_next = spq_pkg::ST_FULL;
            end
            else
            begin
                if (do_remove)
                    count_next = count_reg - spq_pkg::CNT_W'(1);
                else
                    status_next = spq_pkg::ST_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= spq_pkg::ST_OK;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            if (accept)
                status_reg <= status_next;
            done_reg   <= accept;
        end
    end

    // the cells and the count settle at the same edge as done rises, so the
    // front is read straight out of cell 0; zero it when the queue is empty
    assign done                  = done_reg;
    assign result.is_empty       = (count_reg == '0);
    assign result.front_element  = result.is_empty ? '0 : entries[0].element;
    assign result.front_priority = result.is_empty ? '0 : entries[0].prio;
    assign result.fill_count     = count_reg;
    assign result.status         = status_reg;

endmodule

@@ hdl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on insert keeps it, takes the new entry or takes the left
// neighbor's; on removal takes the right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  logic               left_keep,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               keep,
    output spq_pkg::entry_t    entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // stay in place when this entry ranks at or above the new one
    assign keep  = occupied && (entry_reg.prio >= ctrl.new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (keep)
                entry_next = entry_reg;
            else if (left_keep)
                entry_next = ctrl.new_entry;
            else
                entry_next = left_entry;
        end
        else if (ctrl.remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
